### hw/rtl/lpbd_pkg.sv
package lpbd_pkg;

	localparam int CAP_W      = 5;
	localparam int PAGE_IN_W  = 32;
	localparam int SLOT_OUT_W = 4;
	localparam int EVPG_OUT_W = 32;
	localparam int OUT_W      = 40;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// per-request control broadcast along the cell row
	typedef struct packed {
		logic accept;
		logic update;
		logic hit;
	} lpbd_ctl_t;

endpackage

### hw/rtl/lpbd_cell.sv
module lpbd_cell import lpbd_pkg::*; #(
	parameter int P         = 0,
	parameter int IW        = 4,
	parameter int UW        = 5,
	parameter int PAGE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lpbd_ctl_t            ctl,
	input  logic [PAGE_BITS-1:0] page_in,
	input  logic [UW-1:0]        miss_lim,
	input  logic                 found_in,
	output logic                 found_out,
	input  logic [IW-1:0]        prev_sid,
	input  logic [PAGE_BITS-1:0] prev_tag,
	input  logic                 prev_valid,
	output logic                 shift_en,
	output logic [IW-1:0]        sid,
	output logic [PAGE_BITS-1:0] tag,
	output logic                 valid
);

	localparam logic [UW-1:0] POS = UW'(P);
	localparam logic [IW-1:0] SID_RESET = IW'(P);

	logic [IW-1:0]        sid_q;
	logic [PAGE_BITS-1:0] tag_q;
	logic                 valid_q;
	logic                 match_q;

	assign found_out = found_in | match_q;
	// on a hit everything up to the first matching position shifts
	assign shift_en  = ctl.hit ? !found_in : (POS <= miss_lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sid_q   <= SID_RESET;
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctl.accept) begin
				match_q <= valid_q && (tag_q == page_in);
			end
			if (ctl.update && shift_en) begin
				sid_q   <= prev_sid;
				valid_q <= prev_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.update && shift_en) begin
			tag_q <= prev_tag;
		end
	end

	assign sid   = sid_q;
	assign tag   = tag_q;
	assign valid = valid_q;

endmodule

### hw/rtl/lru_page_buffer_directory_core.sv
// Channel  | Signals                          | Carries
// ---------+----------------------------------+-------------------------------------------
// s_*      | s_tvalid s_tready s_tdata[31:0]  | page_number
// m_*      | m_tvalid m_tready m_tdata[39:0]  | hit, slot, evicted, evicted_page
// cfg_*    | cfg_valid cfg_ready cfg_data[4:0]| capacity
//
// Per request, tags are compared in the row of cells on the accept edge; the first-match
// chain and move-to-front shift run later, in the update cycle, once the output is free.
// One request in flight; s_tready is low while it is in the row.
// A stalled m_tvalid holds the update cycle until the output register frees up.
// arst_n empties the directory at once: no clearing sweep.
module lru_page_buffer_directory_core import lpbd_pkg::*; #(
	parameter int NUM_SLOTS = 16,
	parameter int PAGE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [PAGE_IN_W-1:0] s_tdata,   // [31:0] page_number
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // [0] hit, [4:1] slot, [5] evicted,
	                                        // [37:6] evicted_page, [39:38] zero
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CAP_W-1:0]     cfg_data   // [4:0] capacity
);

	localparam int IW = $clog2(NUM_SLOTS);
	localparam int UW = $clog2(NUM_SLOTS + 1);
	localparam int CW = (UW > CAP_W) ? UW : CAP_W;
	localparam logic [CW-1:0] NSLOTS_C = CW'(NUM_SLOTS);
	localparam logic [CW-1:0] ONE_C    = CW'(1);

	logic                 busy_q;
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;
	logic [CAP_W-1:0]     cap_q;
	logic [UW-1:0]        used_q;
	logic [PAGE_BITS-1:0] page_s1;

	lpbd_ctl_t            ctl;
	logic                 accept;
	logic [PAGE_BITS-1:0] page_in;
	logic [PAGE_BITS+PAGE_IN_W-1:0] page_ext;

	logic [CW-1:0]        cap_ext;
	logic [CW-1:0]        cap_eff;
	logic [CW-1:0]        used_ext;
	logic                 room;
	logic [UW-1:0]        miss_lim;

	logic [NUM_SLOTS:0]   found;
	logic [NUM_SLOTS-1:0] shift_en;
	logic [NUM_SLOTS-1:0] sel;
	logic [NUM_SLOTS-1:0] valid_vec;
	logic [IW-1:0]        sid_arr   [NUM_SLOTS];
	logic [PAGE_BITS-1:0] tag_arr   [NUM_SLOTS];
	logic [IW-1:0]        sel_sid;
	logic [PAGE_BITS-1:0] sel_tag;
	logic                 sel_valid;

	logic [IW+SLOT_OUT_W-1:0]     slot_ext;
	logic [PAGE_BITS+EVPG_OUT_W-1:0] evpg_ext;
	logic                         evicted;
	logic [EVPG_OUT_W-1:0]        evpg;

	assign s_tready  = !busy_q;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign page_ext  = {{PAGE_BITS{1'b0}}, s_tdata};
	assign page_in   = page_ext[PAGE_BITS-1:0];

	assign ctl.accept = accept;
	assign ctl.update = busy_q && (!out_valid_q || m_tready);
	assign ctl.hit    = found[NUM_SLOTS];

	// effective capacity: zero acts as one, saturates at the slot count
	always_comb begin
		cap_ext  = CW'(cap_q);
		used_ext = CW'(used_q);
		if (cap_ext == '0) begin
			cap_eff = ONE_C;
		end else if (cap_ext > NSLOTS_C) begin
			cap_eff = NSLOTS_C;
		end else begin
			cap_eff = cap_ext;
		end
		room     = used_ext < cap_eff;
		miss_lim = room ? used_q : (used_q - UW'(1));
	end

	assign found[0] = 1'b0;

	for (genvar p = 0; p < NUM_SLOTS; p++) begin : g_cell
		logic [IW-1:0]        prev_sid;
		logic [PAGE_BITS-1:0] prev_tag;
		logic                 prev_valid;

		if (p == 0) begin : g_head
			assign prev_sid   = sel_sid;
			assign prev_tag   = page_s1;
			assign prev_valid = 1'b1;
		end else begin : g_body
			assign prev_sid   = sid_arr[p-1];
			assign prev_tag   = tag_arr[p-1];
			assign prev_valid = valid_vec[p-1];
		end

		lpbd_cell #(
			.P         (p),
			.IW        (IW),
			.UW        (UW),
			.PAGE_BITS (PAGE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.page_in    (page_in),
			.miss_lim   (miss_lim),
			.found_in   (found[p]),
			.found_out  (found[p+1]),
			.prev_sid   (prev_sid),
			.prev_tag   (prev_tag),
			.prev_valid (prev_valid),
			.shift_en   (shift_en[p]),
			.sid        (sid_arr[p]),
			.tag        (tag_arr[p]),
			.valid      (valid_vec[p])
		);

		// last shifting position is the entry that moves to the front
		if (p == NUM_SLOTS - 1) begin : g_sel_last
			assign sel[p] = shift_en[p];
		end else begin : g_sel
			assign sel[p] = shift_en[p] && !shift_en[p+1];
		end
	end

	always_comb begin
		sel_sid   = '0;
		sel_tag   = '0;
		sel_valid = 1'b0;
		for (int p = 0; p < NUM_SLOTS; p++) begin
			sel_sid   = sel_sid | (sel[p] ? sid_arr[p] : '0);
			sel_tag   = sel_tag | (sel[p] ? tag_arr[p] : '0);
			sel_valid = sel_valid | (sel[p] && valid_vec[p]);
		end
	end

	assign slot_ext = {{SLOT_OUT_W{1'b0}}, sel_sid};
	assign evicted  = !ctl.hit && !room;
	assign evpg_ext = {{EVPG_OUT_W{1'b0}}, ((evicted && sel_valid) ? sel_tag : '0)};
	assign evpg     = evpg_ext[EVPG_OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			cap_q       <= CAP_RESET;
			used_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (ctl.update) begin
				busy_q <= 1'b0;
			end
			if (ctl.update) begin
				out_valid_q <= 1'b1;
				if (!ctl.hit && room) begin
					used_q <= used_q + UW'(1);
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_s1 <= page_in;
		end
		if (ctl.update) begin
			out_data_q <= {2'b00, evpg, evicted, slot_ext[SLOT_OUT_W-1:0], ctl.hit};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef ASSERT_OFF
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[5]))
		else $error("hit and eviction reported together");

	a_one_moves: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.update |-> $onehot(sel))
		else $error("move-to-front select not one-hot");

	a_used_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(used_q))
		else $error("valid cells disagree with used count");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.update && !ctl.hit && !room |=> $stable(used_q))
		else $error("used count moved on eviction");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import lpbd_pkg::*;

	localparam int SLOTS          = 16;
	localparam int HOT_POOL       = 32;
	localparam int PHASE_ITEMS    = 130;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int STALL_AT       = 300;
	localparam int STALL_CYCLES   = 250;
	localparam int CALM_FROM      = 600;
	localparam int CALM_TO        = 900;

	// m_tdata layout, lowest bit last
	typedef struct packed {
		logic [1:0]            pad;
		logic [EVPG_OUT_W-1:0] evicted_page;
		logic                  evicted;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  hit;
	} dir_result_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [PAGE_IN_W-1:0] s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CAP_W-1:0]     cfg_data  = '0;

	lru_page_buffer_directory_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// directory mirror
	logic [PAGE_IN_W-1:0] tag_mem [SLOTS];
	bit                   tag_live [SLOTS];
	logic [3:0]           use_order [SLOTS];
	int                   live_count;
	logic [CAP_W-1:0]     cap_reg;

	logic [PAGE_IN_W-1:0] pages_to_send [$];
	dir_result_t          lookup_results_due [$];
	logic [PAGE_IN_W-1:0] hot_pages [HOT_POOL];

	int          mismatches = 0;
	int          pages_sent = 0;
	int          results_seen = 0;
	int          stall_left = 0;
	bit          stalled_once = 0;
	int          quiet_cycles = 0;
	dir_result_t seen_res;
	dir_result_t want_res;

	function automatic int cap_limit();
		if (cap_reg == 0)
			return 1;
		if (cap_reg > SLOTS)
			return SLOTS;
		return cap_reg;
	endfunction

	// look up a page, update recency, return what the directory should report
	function automatic dir_result_t lru_access(input logic [PAGE_IN_W-1:0] page);
		dir_result_t r;
		int          pos;
		bit          found;
		logic [3:0]  s;
		r = '0;
		found = 0;
		pos = 0;
		for (int p = 0; p < live_count; p++) begin
			if (!found && tag_live[use_order[p]] && tag_mem[use_order[p]] == page) begin
				found = 1;
				pos = p;
			end
		end
		if (!found) begin
			if (live_count < cap_limit()) begin
				pos = live_count;
				live_count++;
			end else begin
				// full (or capacity lowered): reuse least recent used slot
				pos = live_count - 1;
				r.evicted = 1'b1;
			end
		end
		s = use_order[pos];
		for (int p = pos; p > 0; p--)
			use_order[p] = use_order[p - 1];
		use_order[0] = s;
		if (r.evicted && tag_live[s])
			r.evicted_page = tag_mem[s];
		tag_mem[s] = page;
		tag_live[s] = 1;
		r.hit = found;
		r.slot = s;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 100)
			$display("tb: mismatch #%0d at %0t: %s", mismatches, $realtime, what);
	endtask

	// driver: one request per handshake, prediction taken on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				lookup_results_due.push_back(lru_access(s_tdata));
				pages_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pages_to_send.size() > 0 &&
				    !((pages_sent < CALM_FROM || pages_sent >= CALM_TO) &&
				      $urandom_range(0, 99) < 10)) begin
					s_tvalid <= 1'b1;
					s_tdata <= pages_to_send.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare against oldest prediction, random and long back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen_res = dir_result_t'(m_tdata);
				if (lookup_results_due.size() == 0) begin
					report_mismatch($sformatf("result %h with no request pending", m_tdata));
				end else begin
					want_res = lookup_results_due.pop_front();
					if (seen_res.hit !== want_res.hit)
						report_mismatch($sformatf("hit %b, want %b",
							seen_res.hit, want_res.hit));
					if (seen_res.slot !== want_res.slot)
						report_mismatch($sformatf("slot %0d, want %0d",
							seen_res.slot, want_res.slot));
					if (seen_res.evicted !== want_res.evicted)
						report_mismatch($sformatf("evicted %b, want %b",
							seen_res.evicted, want_res.evicted));
					if (seen_res.evicted_page !== want_res.evicted_page)
						report_mismatch($sformatf("evicted_page %h, want %h",
							seen_res.evicted_page, want_res.evicted_page));
					if (seen_res.pad !== 2'b00)
						report_mismatch($sformatf("pad bits %b not zero", seen_res.pad));
				end
				results_seen++;
				if (results_seen == STALL_AT && !stalled_once) begin
					stall_left = STALL_CYCLES;
					stalled_once = 1;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !((results_seen < CALM_FROM || results_seen >= CALM_TO) &&
				              $urandom_range(0, 99) < 10);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			    (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	task automatic drain();
		while (pages_to_send.size() > 0 || s_tvalid || lookup_results_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] value);
		drain();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_reg = value;
	endtask

	// mostly a working set sized around capacity so hits and evictions mix
	task automatic queue_phase(input int count);
		int                   ws;
		int                   roll;
		int                   idx;
		logic [PAGE_IN_W-1:0] page;
		ws = cap_limit() + $urandom_range(0, 4);
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			idx = $urandom_range(0, ws - 1);
			if (roll < 75) begin
				page = hot_pages[idx];
			end else if (roll < 90) begin
				hot_pages[idx] = $urandom;
				page = hot_pages[idx];
			end else if (roll < 95) begin
				page = $urandom;
			end else begin
				page = $urandom_range(0, 1) ? '1 : '0;
			end
			pages_to_send.push_back(page);
		end
	endtask

	logic [CAP_W-1:0] cap_plan [11];

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			tag_mem[i] = '0;
			tag_live[i] = 0;
			use_order[i] = i[3:0];
		end
		live_count = 0;
		cap_reg = CAP_RESET;
		for (int i = 0; i < HOT_POOL; i++)
			hot_pages[i] = $urandom;
		cap_plan = '{5'd1, 5'd0, 5'd31, 5'd4, 5'd16, 5'd2, 5'd17, 5'd9, 5'd12, 5'd3, 5'd0};
		cap_plan[10] = $urandom_range(0, 31);

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// page zero must miss in an empty directory whatever the unreset tags hold
		pages_to_send.push_back(32'h0000_0000);
		pages_to_send.push_back(32'h0000_0000);
		pages_to_send.push_back(32'hFFFF_FFFF);
		pages_to_send.push_back(32'h8000_0000);
		pages_to_send.push_back(32'h0000_0001);
		pages_to_send.push_back(32'hFFFF_FFFF);
		pages_to_send.push_back(32'h0000_0000);
		// fill and overflow the directory: least recent pages get evicted
		for (int i = 0; i < 16; i++)
			pages_to_send.push_back(32'h5A5A_0000 + i * 32'h0001_0101);
		pages_to_send.push_back(32'h0000_0000);
		queue_phase(PHASE_ITEMS);

		// first change drops capacity below the slots in use
		foreach (cap_plan[k]) begin
			set_capacity(cap_plan[k]);
			queue_phase(PHASE_ITEMS);
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
